/* rtl/bmp_pkg.sv */
// Package with shared types and constants of the BMP pixel stream decoder.
`default_nettype none
package bmp_pkg;
  localparam int CoordBitsDefault = 14;
  localparam logic [13:0] MaxDimReset = 14'd10000;
  localparam logic [31:0] HeaderBytes = 32'd54;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_HDR_SHORT  = 3'd1;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd2;
  localparam logic [2:0] ST_DEPTH      = 3'd3;
  localparam logic [2:0] ST_COMPRESSED = 3'd4;
  localparam logic [2:0] ST_WIDTH      = 3'd5;
  localparam logic [2:0] ST_HEIGHT     = 3'd6;
  localparam logic [2:0] ST_PIX_SHORT  = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] x;
    logic [13:0] y;
    logic [7:0]  chan_red;
    logic [7:0]  chan_green;
    logic [7:0]  chan_blue;
    logic [1:0]  channels;
    logic [2:0]  status;
    logic        image_done;
  } result_t;
endpackage
`default_nettype wire

/* rtl/bmp_if.sv */
// Valid/ready stream interfaces for the input bytes and the result items.
`default_nettype none
interface bmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_file;
  modport source (output valid, byte_value, end_of_file, input ready);
  modport sink (input valid, byte_value, end_of_file, output ready);
endinterface

interface bmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [13:0] x;
  logic [13:0] y;
  logic [7:0]  chan_red;
  logic [7:0]  chan_green;
  logic [7:0]  chan_blue;
  logic [1:0]  channels;
  logic [2:0]  status;
  logic        image_done;
  modport source (output valid, kind, x, y, chan_red, chan_green, chan_blue, channels,
                  status, image_done, input ready);
  modport sink (input valid, kind, x, y, chan_red, chan_green, chan_blue, channels,
                status, image_done, output ready);
endinterface
`default_nettype wire

/* rtl/bmp_pixel_stream_decoder.sv */
// Top level of the BMP pixel stream decoder.
// Takes one file byte per beat and, at one beat per clock, yields at most one result beat
// (pixel, empty image or error) per input byte; a result leaves at the earliest the cycle
// after its byte. The input is stalled only when the two-entry result queue is full and
// the output is not being drained. Decodes only uncompressed 8-bit grey and 24-bit BGR;
// write max_dimension (cfg_wr_en/cfg_wr_data) only while idle; the block does not check.
`default_nettype none
module bmp_pixel_stream_decoder #(
  parameter int COORD_BITS = bmp_pkg::CoordBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bmp_in_if.sink           in_ch,
  bmp_out_if.source        out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [13:0] cfg_wr_data
);
  import bmp_pkg::*;
  logic [13:0] max_dim_r;
  logic        res_valid, res_space;
  result_t     res_data, q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) max_dim_r <= MaxDimReset;
    else if (cfg_wr_en) max_dim_r <= cfg_wr_data;
  end

  bmp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_byte(in_ch.byte_value),
    .in_eof(in_ch.end_of_file), .in_ready(in_ch.ready), .max_dim(max_dim_r),
    .res_valid, .res_data, .res_space
  );

  bmp_queue u_queue (
    .clk, .rst_n, .wr_en(res_valid), .wr_data(res_data), .has_space(res_space),
    .rd_valid(out_ch.valid), .rd_data(q_data), .rd_en(out_ch.ready)
  );

  assign out_ch.kind = q_data.kind;
  assign out_ch.x = q_data.x;
  assign out_ch.y = q_data.y;
  assign out_ch.chan_red = q_data.chan_red;
  assign out_ch.chan_green = q_data.chan_green;
  assign out_ch.chan_blue = q_data.chan_blue;
  assign out_ch.channels = q_data.channels;
  assign out_ch.status = q_data.status;
  assign out_ch.image_done = q_data.image_done;

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_ERROR |-> out_ch.image_done)
    else $error("error beat without image_done");
  a_pix_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_PIXEL |-> out_ch.status == ST_OK)
    else $error("pixel beat with nonzero status");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.ready && $past(!out_ch.ready) && out_ch.valid && $past(out_ch.valid)
    && $past(!in_ch.ready) |-> !in_ch.ready)
    else $error("input taken while queue full");
endmodule
`default_nettype wire

/* rtl/bmp_front.sv */
// Front end: parses the header, tracks position and turns bytes into result items.
`default_nettype none
module bmp_front #(
  parameter int COORD_BITS = bmp_pkg::CoordBitsDefault
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_eof,
  output logic                  in_ready,
  input  wire logic [13:0]      max_dim,
  output logic                  res_valid,
  output bmp_pkg::result_t      res_data,
  input  wire logic             res_space
);
  import bmp_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SEEK   = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;
  localparam logic [COORD_BITS-1:0] CoordMask = {COORD_BITS{1'b1}};

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] offs_r, offs_nxt;
  logic [31:0] wid_r, wid_nxt;
  logic [31:0] hgt_r, hgt_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [31:0] comp_r, comp_nxt;
  logic [2:0]  perr_r, perr_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [1:0]  pbi_r, pbi_nxt;
  logic [15:0] bg_r, bg_nxt;
  logic [1:0]  pad_r, pad_nxt;
  // Precomputed per-image values, valid once the header is complete.
  logic [31:0] absh_r, absh_nxt;
  logic        rgb_r, rgb_nxt;
  logic [1:0]  rowpad_r, rowpad_nxt;

  logic        fire;
  logic [31:0] lim, absh_c;
  logic [2:0]  chk;
  logic        emit;
  result_t     res;
  logic [COORD_BITS-1:0] col_inc, row_inc;
  logic [31:0] ycalc;

  assign in_ready = res_space;
  assign fire = in_valid && in_ready;

  always_comb begin
    lim = ({18'd0, max_dim} < {{(32-COORD_BITS){1'b0}}, CoordMask}) ?
          {18'd0, max_dim} : {{(32-COORD_BITS){1'b0}}, CoordMask};
    absh_c = hgt_r[31] ? (~hgt_r + 32'd1) : hgt_r;
    chk = ST_OK;
    if (!(depth_r == 16'd8 || depth_r == 16'd24)) chk = ST_DEPTH;
    else if (comp_r != 32'd0) chk = ST_COMPRESSED;
    else if (wid_r[31] || wid_r > lim) chk = ST_WIDTH;
    else if (absh_c > lim) chk = ST_HEIGHT;
  end

  always_comb begin
    logic pix;
    phase_nxt = phase_r; pos_nxt = pos_r; offs_nxt = offs_r; wid_nxt = wid_r;
    hgt_nxt = hgt_r; depth_nxt = depth_r; comp_nxt = comp_r; perr_nxt = perr_r;
    col_nxt = col_r; row_nxt = row_r; pbi_nxt = pbi_r; bg_nxt = bg_r; pad_nxt = pad_r;
    absh_nxt = absh_r; rgb_nxt = rgb_r; rowpad_nxt = rowpad_r;
    emit = 1'b0; pix = 1'b0;
    res = '0;
    res.channels = 2'd1;
    col_inc = col_r + 1'b1;
    row_inc = row_r + 1'b1;
    ycalc = absh_r - 32'd1 - {{(32-COORD_BITS){1'b0}}, row_r};
    unique case (phase_r)
      PH_HEADER: begin
        unique case (pos_r[5:0])
          6'd10: offs_nxt[7:0] = in_byte;   6'd11: offs_nxt[15:8] = in_byte;
          6'd12: offs_nxt[23:16] = in_byte; 6'd13: offs_nxt[31:24] = in_byte;
          6'd18: wid_nxt[7:0] = in_byte;    6'd19: wid_nxt[15:8] = in_byte;
          6'd20: wid_nxt[23:16] = in_byte;  6'd21: wid_nxt[31:24] = in_byte;
          6'd22: hgt_nxt[7:0] = in_byte;    6'd23: hgt_nxt[15:8] = in_byte;
          6'd24: hgt_nxt[23:16] = in_byte;  6'd25: hgt_nxt[31:24] = in_byte;
          6'd28: depth_nxt[7:0] = in_byte;  6'd29: depth_nxt[15:8] = in_byte;
          6'd30: comp_nxt[7:0] = in_byte;   6'd31: comp_nxt[15:8] = in_byte;
          6'd32: comp_nxt[23:16] = in_byte; 6'd33: comp_nxt[31:24] = in_byte;
          default: ;
        endcase
        if (pos_r == HeaderBytes - 32'd1) begin
          if (offs_r < HeaderBytes) begin
            emit = 1'b1; res.kind = KIND_ERROR; res.status = ST_BAD_OFFSET;
            res.image_done = 1'b1; phase_nxt = PH_DONE;
          end else begin
            perr_nxt = chk; phase_nxt = PH_SEEK;
            absh_nxt = absh_c;
            rgb_nxt = (depth_r == 16'd24);
            rowpad_nxt = (depth_r == 16'd24) ? (2'd0 - (wid_r[1:0] * 2'd3))
                                             : (2'd0 - wid_r[1:0]);
          end
        end
      end
      PH_SEEK: begin
        if (pos_r == offs_r) begin
          if (perr_r != ST_OK) begin
            emit = 1'b1; res.kind = KIND_ERROR; res.status = perr_r;
            res.image_done = 1'b1; phase_nxt = PH_DONE;
          end else if (wid_r == 32'd0 || absh_r == 32'd0) begin
            emit = 1'b1; res.kind = KIND_EMPTY; res.channels = rgb_r ? 2'd3 : 2'd1;
            res.image_done = 1'b1; phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_PIXELS; pix = 1'b1;
          end
        end
      end
      PH_PIXELS: pix = 1'b1;
      default: ;
    endcase
    if (pix) begin
      if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
      end else if (rgb_r && pbi_r < 2'd2) begin
        if (pbi_r == 2'd0) bg_nxt[7:0] = in_byte;
        else bg_nxt[15:8] = in_byte;
        pbi_nxt = pbi_r + 2'd1;
      end else begin
        emit = 1'b1;
        pbi_nxt = 2'd0;
        res.kind = KIND_PIXEL;
        res.x = 14'(col_r);
        res.y = hgt_r[31] ? 14'(row_r) : 14'(ycalc);
        res.chan_red = in_byte;
        res.chan_green = rgb_r ? bg_r[15:8] : 8'd0;
        res.chan_blue = rgb_r ? bg_r[7:0] : 8'd0;
        res.channels = rgb_r ? 2'd3 : 2'd1;
        col_nxt = col_inc;
        if ({{(32-COORD_BITS){1'b0}}, col_inc} == wid_r) begin
          col_nxt = '0;
          row_nxt = row_inc;
          pad_nxt = rowpad_r;
          if ({{(32-COORD_BITS){1'b0}}, row_inc} == absh_r) begin
            res.image_done = 1'b1; phase_nxt = PH_DONE;
          end
        end
      end
    end
    if (pos_r != 32'hFFFF_FFFF) pos_nxt = pos_r + 32'd1;
    if (in_eof) begin
      if (phase_nxt != PH_DONE) begin
        emit = 1'b1; res = '0; res.kind = KIND_ERROR; res.channels = 2'd1;
        res.image_done = 1'b1;
        res.status = (phase_nxt == PH_HEADER) ? ST_HDR_SHORT :
                     (phase_nxt == PH_SEEK) ? ST_BAD_OFFSET : ST_PIX_SHORT;
      end
      phase_nxt = PH_HEADER; pos_nxt = '0; offs_nxt = '0; wid_nxt = '0; hgt_nxt = '0;
      depth_nxt = '0; comp_nxt = '0; perr_nxt = ST_OK; col_nxt = '0; row_nxt = '0;
      pbi_nxt = '0; bg_nxt = '0; pad_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; pos_r <= '0; offs_r <= '0; wid_r <= '0; hgt_r <= '0;
      depth_r <= '0; comp_r <= '0; perr_r <= ST_OK; col_r <= '0; row_r <= '0;
      pbi_r <= '0; bg_r <= '0; pad_r <= '0; absh_r <= '0; rgb_r <= 1'b0;
      rowpad_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; offs_r <= offs_nxt; wid_r <= wid_nxt;
      hgt_r <= hgt_nxt; depth_r <= depth_nxt; comp_r <= comp_nxt; perr_r <= perr_nxt;
      col_r <= col_nxt; row_r <= row_nxt; pbi_r <= pbi_nxt; bg_r <= bg_nxt;
      pad_r <= pad_nxt; absh_r <= absh_nxt; rgb_r <= rgb_nxt; rowpad_r <= rowpad_nxt;
    end
  end

  assign res_valid = fire && emit;
  assign res_data = res;
endmodule
`default_nettype wire

/* rtl/bmp_queue.sv */
// Two-entry result queue between the parser and the output channel.
`default_nettype none
module bmp_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  bmp_pkg::result_t wr_data,
  output logic             has_space,
  output logic             rd_valid,
  output bmp_pkg::result_t rd_data,
  input  wire logic        rd_en
);
  import bmp_pkg::*;
  result_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop = rd_en && rd_valid;
  assign has_space = (cnt_r != 2'd2) || rd_en;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire
